/* rtl/core/flash_image_crc32_checker_macros.svh */
// Assertion macros shared by the checker's RTL files.
`ifndef FLASH_IMAGE_CRC32_CHECKER_MACROS_SVH
`define FLASH_IMAGE_CRC32_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define FICC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define FICC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define FICC_ASSERT(label, clk, rst_n, prop, msg)
`define FICC_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/ficc_pkg.sv */
`default_nettype none

package ficc_pkg;

  localparam int unsigned CrcW            = 32;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned FlashSizeW      = 25;
  localparam int unsigned FlashAddrBitsDef = 24;

  localparam logic [CrcW-1:0]  CrcPoly  = 32'hEDB8_8320;
  localparam logic [ByteW-1:0] FillByte = 8'hFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic fold_in;    // fold the accepted input beat
    logic fold_fill;  // fold one 0xFF padding byte
    logic load_out;   // capture result, restart image
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pad_done;   // byte count reached the padded size
  } dp_sts_t;

  // Reflected CRC-32 table entry for one index byte
  function automatic logic [CrcW-1:0] crc_table_f(input logic [ByteW-1:0] idx);
    logic [CrcW-1:0] c;
    c = {{(CrcW-ByteW){1'b0}}, idx};
    for (int b = 0; b < ByteW; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // One byte-wise CRC update
  function automatic logic [CrcW-1:0] crc_fold_f(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] data);
    return crc_table_f(crc[ByteW-1:0] ^ data) ^ (crc >> ByteW);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ficc_dp.sv */
`default_nettype none
`include "flash_image_crc32_checker_macros.svh"

module ficc_dp #(
  parameter int unsigned FlashAddrBits = ficc_pkg::FlashAddrBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ficc_pkg::dp_cmd_t                cmd_i,
  output      ficc_pkg::dp_sts_t                sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ficc_pkg::FlashSizeW-1:0]  cfg_flash_size_i,
  input  wire logic [ficc_pkg::ByteW-1:0]       data_byte_i,
  input  wire logic [ficc_pkg::CrcW-1:0]        expected_crc_i,
  output      logic [ficc_pkg::CrcW-1:0]        image_crc_o,
  output      logic                             crc_match_o
);

  localparam int unsigned CntW = FlashAddrBits + 1;
  localparam int unsigned CmpW = (CntW > ficc_pkg::FlashSizeW) ? CntW : ficc_pkg::FlashSizeW;
  localparam logic [CmpW-1:0] Limit = CmpW'(1) << FlashAddrBits;

  logic [ficc_pkg::FlashSizeW-1:0] flash_size_q;
  logic [ficc_pkg::CrcW-1:0]       crc_q, crc_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [ficc_pkg::CrcW-1:0]       exp_q;
  logic [ficc_pkg::CrcW-1:0]       res_crc_q;
  logic                            res_match_q;
  logic [CmpW-1:0]                 size_ext, target, cnt_ext;
  logic [ficc_pkg::ByteW-1:0]      fold_byte;

  // Padding target, clamped to the addressable flash
  assign size_ext = CmpW'(flash_size_q);
  assign target   = (size_ext > Limit) ? Limit : size_ext;
  assign cnt_ext  = CmpW'(cnt_q);
  assign sts_o.pad_done = (cnt_ext >= target);

  assign fold_byte = cmd_i.fold_fill ? ficc_pkg::FillByte : data_byte_i;

  // Next CRC and count
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (cmd_i.load_out) begin
      crc_d = '0;
      cnt_d = '0;
    end else if (cmd_i.fold_in || cmd_i.fold_fill) begin
      crc_d = ficc_pkg::crc_fold_f(crc_q, fold_byte);
      if (cnt_ext < Limit) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // Control state: running CRC, count, flash size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= '0;
      cnt_q        <= '0;
      flash_size_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        flash_size_q <= cfg_flash_size_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fold_in) begin
      exp_q <= expected_crc_i;
    end
    if (cmd_i.load_out) begin
      res_crc_q   <= crc_q;
      res_match_q <= (crc_q == exp_q);
    end
  end

  assign image_crc_o = res_crc_q;
  assign crc_match_o = res_match_q;

  `FICC_ASSERT_NEVER(a_cnt_sat, clk_i, rst_ni, cnt_ext > Limit, "byte count above limit")
  `FICC_ASSERT(a_restart, clk_i, rst_ni, cmd_i.load_out |=> (crc_q == '0 && cnt_q == '0),
               "image state not cleared after result")
  `FICC_ASSERT_NEVER(a_fill_past, clk_i, rst_ni, cmd_i.fold_fill && sts_o.pad_done,
                     "padding past target")

endmodule

`default_nettype wire

/* rtl/core/ficc_ctrl.sv */
`default_nettype none
`include "flash_image_crc32_checker_macros.svh"

module ficc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_byte_i,
  output      logic              in_stall_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      ficc_pkg::dp_cmd_t cmd_o,
  input  wire ficc_pkg::dp_sts_t sts_i
);

  typedef enum logic [0:0] {
    StRun,  // taking image bytes
    StPad   // folding fill bytes, then result
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o = (state_q != StRun);
  assign in_acc     = in_valid_i && (state_q == StRun);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Datapath commands
  always_comb begin
    cmd_o.fold_in   = in_acc;
    cmd_o.fold_fill = (state_q == StPad) && !sts_i.pad_done;
    cmd_o.load_out  = (state_q == StPad) && sts_i.pad_done && out_free;
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StRun: begin
          if (in_acc && last_byte_i) begin
            state_q <= StPad;
          end
        end
        StPad: begin
          if (cmd_o.load_out) begin
            state_q <= StRun;
          end
        end
        default: state_q <= StRun;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `FICC_ASSERT(a_last_pad, clk_i, rst_ni, (in_acc && last_byte_i) |=> (state_q == StPad),
               "last beat did not start padding")
  `FICC_ASSERT(a_load_out, clk_i, rst_ni, cmd_o.load_out |=> (out_valid_q && state_q == StRun),
               "result not presented after padding")
  `FICC_ASSERT_NEVER(a_one_cmd, clk_i, rst_ni, cmd_o.fold_in && (state_q == StPad),
                     "byte folded during padding")

endmodule

`default_nettype wire

/* rtl/core/flash_image_crc32_checker.sv */
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// in       | in        | in_valid_i/in_stall_o | data_byte_i, last_byte_i, expected_crc_i
// out      | out       | out_valid_o/out_stall_i | image_crc_o, crc_match_o
// cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_flash_size_i
//
// Image bytes are taken one per cycle while in_stall_o is low; the single CRC update per cycle sets this.
// After the last beat, in_stall_o stays high while 0xFF fill bytes pad the image to
// the flash size and until the result loads (delayed while a previous result stalls).
// A result waiting on out_stall_i does not block the next image's bytes.
// Reset clears CRC, count, flash size and the result valid; cfg is always ready.
`default_nettype none

module flash_image_crc32_checker #(
  parameter int unsigned FlashAddrBits = ficc_pkg::FlashAddrBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [ficc_pkg::ByteW-1:0]      data_byte_i,
  input  wire logic                            last_byte_i,
  input  wire logic [ficc_pkg::CrcW-1:0]       expected_crc_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [ficc_pkg::CrcW-1:0]       image_crc_o,
  output      logic                            crc_match_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [ficc_pkg::FlashSizeW-1:0] cfg_flash_size_i
);

  ficc_pkg::dp_cmd_t cmd;
  ficc_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ficc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ficc_dp #(
    .FlashAddrBits (FlashAddrBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i),
    .cfg_flash_size_i (cfg_flash_size_i),
    .data_byte_i      (data_byte_i),
    .expected_crc_i   (expected_crc_i),
    .image_crc_o      (image_crc_o),
    .crc_match_o      (crc_match_o)
  );

endmodule

`default_nettype wire

/* tb/flash_image_crc32_checker_tb.sv */
`default_nettype none

module flash_image_crc32_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [ficc_pkg::CrcW-1:0]       crc_t;
  typedef logic [ficc_pkg::ByteW-1:0]      byte_t;
  typedef logic [ficc_pkg::FlashSizeW-1:0] size_t;

  // One finished image as the checker should report it
  typedef struct packed {
    crc_t crc;
    logic match;
  } image_result_t;

  // Tracks the running CRC of the image in flight and the results owed
  class flash_crc_board;
    crc_t          crc_lut[256];
    size_t         count_cap;
    size_t         flash_size;
    crc_t          running_crc;
    size_t         bytes_folded;
    image_result_t expected_images[$];

    function new();
      crc_t c;
      for (int i = 0; i < 256; i++) begin
        c = crc_t'(i);
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ ficc_pkg::CrcPoly) : (c >> 1);
        end
        crc_lut[i] = c;
      end
      count_cap    = size_t'(1) << ficc_pkg::FlashAddrBitsDef;
      flash_size   = '0;
      running_crc  = '0;
      bytes_folded = '0;
    endfunction

    function crc_t fold_crc_byte(crc_t crc, byte_t b);
      return crc_lut[crc[7:0] ^ b] ^ (crc >> 8);
    endfunction

    function void set_flash_size(size_t size);
      flash_size = size;
    endfunction

    // CRC the image would end with if b were its last byte
    function crc_t closing_crc(byte_t b);
      crc_t  c;
      size_t n;
      size_t target;
      c = fold_crc_byte(running_crc, b);
      n = (bytes_folded < count_cap) ? bytes_folded + 1'b1 : bytes_folded;
      target = (flash_size > count_cap) ? count_cap : flash_size;
      while (n < target) begin
        c = fold_crc_byte(c, ficc_pkg::FillByte);
        n++;
      end
      return c;
    endfunction

    // Accepted input beat
    function void note_byte(byte_t b, logic last, crc_t board_crc);
      crc_t c;
      if (last) begin
        c = closing_crc(b);
        expected_images.push_back(image_result_t'{crc: c, match: (c == board_crc)});
        running_crc  = '0;
        bytes_folded = '0;
      end else begin
        running_crc = fold_crc_byte(running_crc, b);
        if (bytes_folded < count_cap) bytes_folded++;
      end
    endfunction

    // Accepted result beat; empty string when it matches the oldest owed result
    function string check_result(crc_t crc, logic match);
      image_result_t want;
      string         msg;
      if (expected_images.size() == 0) begin
        return $sformatf("result with nothing owed: image_crc=%08h crc_match=%b", crc, match);
      end
      want = expected_images.pop_front();
      msg = "";
      if (crc !== want.crc) begin
        msg = $sformatf("image_crc=%08h want %08h ", crc, want.crc);
      end
      if (match !== want.match) begin
        msg = {msg, $sformatf("crc_match=%b want %b", match, want.match)};
      end
      return msg;
    endfunction

    function int owed();
      return expected_images.size();
    endfunction
  endclass

  logic  clk_i            = 1'b0;
  logic  rst_ni           = 1'b0;
  logic  in_valid_i       = 1'b0;
  logic  in_stall_o;
  byte_t data_byte_i      = '0;
  logic  last_byte_i      = 1'b0;
  crc_t  expected_crc_i   = '0;
  logic  out_valid_o;
  logic  out_stall_i      = 1'b0;
  crc_t  image_crc_o;
  logic  crc_match_o;
  logic  cfg_valid_i      = 1'b0;
  logic  cfg_ready_o;
  size_t cfg_flash_size_i = '0;

  flash_crc_board board = new();
  int mismatches    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  flash_image_crc32_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .expected_crc_i   (expected_crc_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .image_crc_o      (image_crc_o),
    .crc_match_o      (crc_match_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_flash_size_i (cfg_flash_size_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Result side: check accepted beats, then pick next cycle's stall
  always @(posedge clk_i) begin
    string verdict;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      verdict = board.check_result(image_crc_o, crc_match_o);
      if (verdict != "") report_mismatch(verdict);
    end
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Drive one input beat; valid stays high afterwards until the next call or a drain
  task automatic send_byte(input byte_t b, input logic last, input crc_t board_crc);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    last_byte_i    <= last;
    expected_crc_i <= board_crc;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, last, board_crc);
  endtask

  // Hold the sender off until every owed result is out, then let the block settle
  task automatic await_idle_board();
    in_valid_i <= 1'b0;
    while (board.owed() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_flash_size(input size_t size);
    await_idle_board();
    cfg_valid_i      <= 1'b1;
    cfg_flash_size_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_flash_size(size);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // Board CRC for the last beat: half the time correct, else random or one bit off
  function automatic crc_t pick_board_crc(byte_t b);
    crc_t good;
    good = board.closing_crc(b);
    case ($urandom_range(3))
      0, 1:    return good;
      2:       return good ^ (crc_t'(1) << $urandom_range(31));
      default: return crc_t'($urandom);
    endcase
  endfunction

  task automatic send_image(input int len);
    byte_t b;
    for (int i = 0; i < len - 1; i++) begin
      send_byte(pick_byte(), 1'b0, crc_t'($urandom));
    end
    b = pick_byte();
    send_byte(b, 1'b1, pick_board_crc(b));
  endtask

  // Mostly small flash sizes; a few larger ones for long padding runs
  function automatic size_t pick_flash_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return size_t'(1);
      7:       return size_t'($urandom_range(300, 41));
      8:       return size_t'($urandom_range(1024, 301));
      default: return size_t'($urandom_range(40, 2));
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Flash size still at reset value zero: no padding at all
    send_byte(8'h00, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1, board.closing_crc(8'hFF));
    send_byte(8'h5A, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'hA5, 1'b0, 32'h0000_0000);
    send_byte(8'hFF, 1'b1, 32'h0000_0000);

    // Image shorter than, equal to and longer than the flash
    write_flash_size(size_t'(4));
    send_image(2);
    send_image(4);
    send_image(5);
    write_flash_size(size_t'(1));
    send_image(1);
    send_image(2);

    // Largest and oversized settings while an image is open, closed at a small size
    write_flash_size(size_t'(1) << ficc_pkg::FlashAddrBitsDef);
    for (int i = 0; i < 3; i++) send_byte(pick_byte(), 1'b0, crc_t'($urandom));
    write_flash_size('1);
    for (int i = 0; i < 3; i++) send_byte(pick_byte(), 1'b0, crc_t'($urandom));
    write_flash_size(size_t'(12));
    send_image(1);

    // Random images under four idling patterns, re-sizing the flash between groups
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 84; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      for (int seg = 0; seg < 9; seg++) begin
        write_flash_size(pick_flash_size());
        sent = 0;
        while (sent < 34) begin
          len = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 1);
          send_image(len);
          sent += len;
        end
      end
    end

    await_idle_board();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #100_000_000;
    $display("TIMEOUT with %0d results still owed", board.owed());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/ficc_pkg.sv
rtl/core/ficc_dp.sv
rtl/core/ficc_ctrl.sv
rtl/core/flash_image_crc32_checker.sv
tb/flash_image_crc32_checker_tb.sv
